@@ hdl/waes_pkg.sv @@
// ----------------------------------------------------------------------------
// waes_pkg
// Shared types and constants for the weighted adjacency edge store.
// ----------------------------------------------------------------------------
package waes_pkg;

  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_MAX_DEGREE  = 8;
  localparam int DEF_WEIGHT_BITS = 32;

  localparam int NODE_W   = 6;
  localparam int NCOUNT_W = 7;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int WOUT_W   = 32;

  localparam logic [NCOUNT_W-1:0] NCOUNT_RST = 7'd64;

  localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_UNDIR = 3'd1;
  localparam logic [OP_W-1:0] OP_IS_CONN   = 3'd2;
  localparam logic [OP_W-1:0] OP_GET_WT    = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST      = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_EDGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DEG_RD,
    ST_DEG_WAIT,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              connected;
    logic [WOUT_W-1:0] weight_out;
    logic [NODE_W-1:0] neighbour;
    logic              item_valid;
    logic              last;
  } res_t;

endpackage

@@ hdl/waes_ram.sv @@
// ----------------------------------------------------------------------------
// waes_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module waes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/waes_outreg.sv @@
// ----------------------------------------------------------------------------
// waes_outreg
// Result register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module waes_outreg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  waes_pkg::res_t  res_in,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_stall,
  output waes_pkg::res_t  res_out
);

  logic           full_r;
  logic           full_nxt;
  waes_pkg::res_t data_r;

  assign ready     = !full_r || !out_stall;
  assign out_valid = full_r;
  assign res_out   = data_r;

  always_comb begin
    if (push) begin
      full_nxt = 1'b1;
    end else begin
      full_nxt = full_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= res_in;
    end
  end

endmodule

@@ hdl/waes_seq.sv @@
// ----------------------------------------------------------------------------
// waes_seq
// Operation sequencer: checks nodes, scans a node's edge list in memory,
// appends edges, and hands results to the result register.
// ----------------------------------------------------------------------------
module waes_seq #(
  parameter int MAX_NODES   = waes_pkg::DEF_MAX_NODES,
  parameter int MAX_DEGREE  = waes_pkg::DEF_MAX_DEGREE,
  parameter int WEIGHT_BITS = waes_pkg::DEF_WEIGHT_BITS,
  localparam int NODE_IW    = $clog2(MAX_NODES),
  localparam int DEG_W      = $clog2(MAX_DEGREE + 1),
  localparam int EADDR_W    = $clog2(MAX_NODES * MAX_DEGREE),
  localparam int EWIDTH     = waes_pkg::NODE_W + WEIGHT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [waes_pkg::NCOUNT_W-1:0]       cfg_node_count,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [waes_pkg::OP_W-1:0]           in_operation,
  input  logic [waes_pkg::NODE_W-1:0]         in_node_from,
  input  logic [waes_pkg::NODE_W-1:0]         in_node_to,
  input  logic signed [31:0]                  in_edge_weight,
  output logic                                res_push,
  output waes_pkg::res_t                      res,
  input  logic                                res_ready,
  output logic                                deg_we,
  output logic [NODE_IW-1:0]                  deg_waddr,
  output logic [DEG_W-1:0]                    deg_wdata,
  output logic [NODE_IW-1:0]                  deg_raddr,
  input  logic [DEG_W-1:0]                    deg_rdata,
  output logic                                edge_we,
  output logic [EADDR_W-1:0]                  edge_waddr,
  output logic [EWIDTH-1:0]                   edge_wdata,
  output logic [EADDR_W-1:0]                  edge_raddr,
  input  logic [EWIDTH-1:0]                   edge_rdata
);

  waes_pkg::state_t                    state_r, state_nxt;
  logic [waes_pkg::NCOUNT_W-1:0]       node_count_r;
  logic [NODE_IW-1:0]                  clr_r, clr_nxt;
  logic [waes_pkg::OP_W-1:0]           op_r, op_nxt;
  logic [waes_pkg::NODE_W-1:0]         a_r, a_nxt;
  logic [waes_pkg::NODE_W-1:0]         b_r, b_nxt;
  logic [WEIGHT_BITS-1:0]              w_r, w_nxt;
  logic [waes_pkg::NODE_W-1:0]         src_r, src_nxt;
  logic [waes_pkg::NODE_W-1:0]         dst_r, dst_nxt;
  logic                                phase_r, phase_nxt;
  logic                                full1_r, full1_nxt;
  logic [DEG_W-1:0]                    deg_r, deg_nxt;
  logic [DEG_W-1:0]                    k_r, k_nxt;
  logic                                found_r, found_nxt;
  logic [WEIGHT_BITS-1:0]              fw_r, fw_nxt;
  waes_pkg::res_t                      res_r, res_nxt;

  logic                                a_ok, b_ok;
  logic [63:0]                         win64;
  logic signed [WEIGHT_BITS-1:0]       fw_s;
  logic [63:0]                         fw64;
  logic [EADDR_W-1:0]                  ebase;
  logic [waes_pkg::NODE_W-1:0]         rd_tgt;
  logic [WEIGHT_BITS-1:0]              rd_wt;
  logic [DEG_W-1:0]                    k_inc;
  logic                                list_full;
  logic                                is_add;

  assign a_ok = ({1'b0, a_r} < node_count_r) && (32'(a_r) < MAX_NODES);
  assign b_ok = ({1'b0, b_r} < node_count_r) && (32'(b_r) < MAX_NODES);

  assign win64  = 64'(in_edge_weight);
  assign fw_s   = fw_r;
  assign fw64   = 64'(fw_s);
  assign ebase  = EADDR_W'(NODE_IW'(src_r)) * EADDR_W'(MAX_DEGREE);
  assign rd_tgt = edge_rdata[EWIDTH-1:WEIGHT_BITS];
  assign rd_wt  = edge_rdata[WEIGHT_BITS-1:0];
  assign k_inc  = k_r + DEG_W'(1);
  assign list_full = (deg_r >= DEG_W'(MAX_DEGREE));
  assign is_add = (op_r == waes_pkg::OP_ADD) || (op_r == waes_pkg::OP_ADD_UNDIR);

  assign in_stall = (state_r != waes_pkg::ST_IDLE);
  assign res      = res_r;

  assign edge_raddr = ebase + EADDR_W'(k_r);
  assign edge_waddr = ebase + EADDR_W'(deg_r);
  assign edge_wdata = {dst_r, w_r};
  assign deg_raddr  = NODE_IW'(src_r);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    w_nxt     = w_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    phase_nxt = phase_r;
    full1_nxt = full1_r;
    deg_nxt   = deg_r;
    k_nxt     = k_r;
    found_nxt = found_r;
    fw_nxt    = fw_r;
    res_nxt   = res_r;
    res_push  = 1'b0;
    deg_we    = 1'b0;
    deg_waddr = NODE_IW'(src_r);
    deg_wdata = deg_r + DEG_W'(1);
    edge_we   = 1'b0;

    unique case (state_r)
      waes_pkg::ST_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_r;
        deg_wdata = '0;
        clr_nxt   = clr_r + NODE_IW'(1);
        if (clr_r == NODE_IW'(MAX_NODES - 1)) begin
          state_nxt = waes_pkg::ST_IDLE;
        end
      end
      waes_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          a_nxt     = in_node_from;
          b_nxt     = in_node_to;
          w_nxt     = win64[WEIGHT_BITS-1:0];
          state_nxt = waes_pkg::ST_CHECK;
        end
      end
      waes_pkg::ST_CHECK: begin
        res_nxt   = '0;
        res_nxt.last = 1'b1;
        src_nxt   = a_r;
        dst_nxt   = b_r;
        phase_nxt = 1'b0;
        full1_nxt = 1'b0;
        if (op_r > waes_pkg::OP_LIST) begin
          state_nxt = waes_pkg::ST_IDLE;
        end else if (!a_ok || (op_r != waes_pkg::OP_LIST && !b_ok)) begin
          res_nxt.status = waes_pkg::STAT_INVALID;
          state_nxt      = waes_pkg::ST_EMIT;
        end else begin
          state_nxt = waes_pkg::ST_DEG_RD;
        end
      end
      waes_pkg::ST_DEG_RD: begin
        state_nxt = waes_pkg::ST_DEG_WAIT;
      end
      waes_pkg::ST_DEG_WAIT: begin
        deg_nxt   = deg_rdata;
        k_nxt     = '0;
        found_nxt = 1'b0;
        if (deg_rdata == '0) begin
          state_nxt = (op_r == waes_pkg::OP_LIST) ? waes_pkg::ST_EMIT
                                                  : waes_pkg::ST_DECIDE;
        end else begin
          state_nxt = waes_pkg::ST_EDGE_RD;
        end
      end
      waes_pkg::ST_EDGE_RD: begin
        state_nxt = waes_pkg::ST_EDGE_CHK;
      end
      waes_pkg::ST_EDGE_CHK: begin
        k_nxt = k_inc;
        if (op_r == waes_pkg::OP_LIST) begin
          res_nxt            = '0;
          res_nxt.neighbour  = rd_tgt;
          res_nxt.item_valid = 1'b1;
          res_nxt.last       = (k_inc == deg_r);
          state_nxt          = waes_pkg::ST_EMIT;
        end else if (rd_tgt == dst_r) begin
          found_nxt = 1'b1;
          fw_nxt    = rd_wt;
          state_nxt = waes_pkg::ST_DECIDE;
        end else if (k_inc == deg_r) begin
          state_nxt = waes_pkg::ST_DECIDE;
        end else begin
          state_nxt = waes_pkg::ST_EDGE_RD;
        end
      end
      waes_pkg::ST_DECIDE: begin
        res_nxt      = '0;
        res_nxt.last = 1'b1;
        state_nxt    = waes_pkg::ST_EMIT;
        if (op_r == waes_pkg::OP_IS_CONN) begin
          res_nxt.connected = found_r;
        end else if (op_r == waes_pkg::OP_GET_WT) begin
          if (found_r) begin
            res_nxt.connected  = 1'b1;
            res_nxt.weight_out = fw64[31:0];
          end else begin
            res_nxt.status = waes_pkg::STAT_NO_EDGE;
          end
        end else if (is_add) begin
          if (!found_r && !list_full) begin
            edge_we = 1'b1;
            deg_we  = 1'b1;
          end
          if (op_r == waes_pkg::OP_ADD_UNDIR && !phase_r) begin
            full1_nxt = !found_r && list_full;
            phase_nxt = 1'b1;
            src_nxt   = dst_r;
            dst_nxt   = src_r;
            state_nxt = waes_pkg::ST_DEG_RD;
          end else if (full1_r || (!found_r && list_full)) begin
            res_nxt.status = waes_pkg::STAT_FULL;
          end
        end
      end
      waes_pkg::ST_EMIT: begin
        if (res_ready) begin
          res_push = 1'b1;
          if (op_r == waes_pkg::OP_LIST && !res_r.last) begin
            state_nxt = waes_pkg::ST_EDGE_RD;
          end else begin
            state_nxt = waes_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = waes_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= waes_pkg::ST_CLEAR;
      clr_r        <= '0;
      node_count_r <= waes_pkg::NCOUNT_RST;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    w_r     <= w_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    phase_r <= phase_nxt;
    full1_r <= full1_nxt;
    deg_r   <= deg_nxt;
    k_r     <= k_nxt;
    found_r <= found_nxt;
    fw_r    <= fw_nxt;
    res_r   <= res_nxt;
  end

endmodule

@@ hdl/weighted_adjacency_edge_store_top.sv @@
// ----------------------------------------------------------------------------
// weighted_adjacency_edge_store_top
// Weighted directed adjacency store: per-node bounded edge lists in RAM.
//
//   channel   direction  handshake          payload
//   in_       input      in_valid/in_stall  operation, node_from, node_to,
//                                           edge_weight
//   out_      output     out_valid/out_stall status, connected, weight_out,
//                                           neighbour, item_valid, last
//   cfg_      input      cfg_wr_en          node_count
//
// Sequence: CHECK, DEG_RD, DEG_WAIT, EDGE_RD and EDGE_CHK per stored edge
// scanned, then DECIDE (not for a listing) and EMIT; an undirected add runs
// the scan twice. A listing returns to EDGE_RD after each neighbour. An
// unknown code is dropped in CHECK; an invalid node goes on to EMIT. Scans
// follow the registered edge RAM read; in_stall is high outside IDLE.
// Reset: a clearing pass over all MAX_NODES entries zeroes the degree RAM;
// in_stall stays high meanwhile.
// Stalls: a result waits in the output register; out_stall holds it there.
// ----------------------------------------------------------------------------
module weighted_adjacency_edge_store_top #(
  parameter int MAX_NODES   = waes_pkg::DEF_MAX_NODES,
  parameter int MAX_DEGREE  = waes_pkg::DEF_MAX_DEGREE,
  parameter int WEIGHT_BITS = waes_pkg::DEF_WEIGHT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [waes_pkg::NCOUNT_W-1:0]     cfg_node_count,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [waes_pkg::OP_W-1:0]         in_operation,
  input  logic [waes_pkg::NODE_W-1:0]       in_node_from,
  input  logic [waes_pkg::NODE_W-1:0]       in_node_to,
  input  logic signed [31:0]                in_edge_weight,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [waes_pkg::STAT_W-1:0]       out_status,
  output logic                              out_connected,
  output logic signed [31:0]                out_weight_out,
  output logic [waes_pkg::NODE_W-1:0]       out_neighbour,
  output logic                              out_item_valid,
  output logic                              out_last
);

  localparam int NODE_IW = $clog2(MAX_NODES);
  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int EDEPTH  = MAX_NODES * MAX_DEGREE;
  localparam int EADDR_W = $clog2(EDEPTH);
  localparam int EWIDTH  = waes_pkg::NODE_W + WEIGHT_BITS;

  logic                 deg_we;
  logic [NODE_IW-1:0]   deg_waddr;
  logic [DEG_W-1:0]     deg_wdata;
  logic [NODE_IW-1:0]   deg_raddr;
  logic [DEG_W-1:0]     deg_rdata;
  logic                 edge_we;
  logic [EADDR_W-1:0]   edge_waddr;
  logic [EWIDTH-1:0]    edge_wdata;
  logic [EADDR_W-1:0]   edge_raddr;
  logic [EWIDTH-1:0]    edge_rdata;
  logic                 res_push;
  logic                 res_ready;
  waes_pkg::res_t       res;
  waes_pkg::res_t       res_out;

  waes_seq #(
    .MAX_NODES   (MAX_NODES),
    .MAX_DEGREE  (MAX_DEGREE),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_node_count (cfg_node_count),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_node_from   (in_node_from),
    .in_node_to     (in_node_to),
    .in_edge_weight (in_edge_weight),
    .res_push       (res_push),
    .res            (res),
    .res_ready      (res_ready),
    .deg_we         (deg_we),
    .deg_waddr      (deg_waddr),
    .deg_wdata      (deg_wdata),
    .deg_raddr      (deg_raddr),
    .deg_rdata      (deg_rdata),
    .edge_we        (edge_we),
    .edge_waddr     (edge_waddr),
    .edge_wdata     (edge_wdata),
    .edge_raddr     (edge_raddr),
    .edge_rdata     (edge_rdata)
  );

  waes_ram #(
    .WIDTH (DEG_W),
    .DEPTH (MAX_NODES)
  ) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  waes_ram #(
    .WIDTH (EWIDTH),
    .DEPTH (EDEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  waes_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .res_in    (res),
    .ready     (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  assign out_status     = res_out.status;
  assign out_connected  = res_out.connected;
  assign out_weight_out = res_out.weight_out;
  assign out_neighbour  = res_out.neighbour;
  assign out_item_valid = res_out.item_valid;
  assign out_last       = res_out.last;

endmodule

@@ hdl/waes_chk.sv @@
// ----------------------------------------------------------------------------
// waes_chk
// Port-level checks for the weighted adjacency edge store.
// ----------------------------------------------------------------------------
module waes_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [waes_pkg::STAT_W-1:0]   out_status,
  input logic                          out_connected,
  input logic [31:0]                   out_weight_out,
  input logic [waes_pkg::NODE_W-1:0]   out_neighbour,
  input logic                          out_item_valid,
  input logic                          out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_weight_out)
      && $stable(out_neighbour) && $stable(out_last))
    else $error("stalled result changed");

  a_run_only_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_item_valid)
    else $error("non-final result outside a listing");

  a_neighbour_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_valid |->
      out_status == waes_pkg::STAT_OK && !out_connected && out_weight_out == 32'd0)
    else $error("listing item carries query fields");

  a_conn_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_connected |-> out_status == waes_pkg::STAT_OK && out_last)
    else $error("connected result with bad status");

endmodule

bind weighted_adjacency_edge_store_top waes_chk u_waes_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_connected  (out_connected),
  .out_weight_out (out_weight_out),
  .out_neighbour  (out_neighbour),
  .out_item_valid (out_item_valid),
  .out_last       (out_last)
);

@@ tb/sv/weighted_adjacency_edge_store_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_adjacency_edge_store_top_test
// Drives edge adds, undirected adds, connectivity and weight queries and
// neighbour listings into the edge store, mirrors the per-node edge lists in
// a scoreboard and checks every result item field by field, under random
// idling on both channels and several node_count settings.
// ----------------------------------------------------------------------------
module weighted_adjacency_edge_store_top_test;

  localparam logic [waes_pkg::OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [waes_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [waes_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;
  localparam int MAX_DEG = waes_pkg::DEF_MAX_DEGREE;
  localparam int NODES = waes_pkg::DEF_MAX_NODES;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 400000;

  class adjacency_tracker;
    logic [waes_pkg::NCOUNT_W-1:0] node_count;
    logic [3:0] degree [NODES];
    logic [waes_pkg::NODE_W-1:0] target [NODES][MAX_DEG];
    logic signed [31:0] weight [NODES][MAX_DEG];
    waes_pkg::res_t pending[$];
    int unsigned mismatches;

    function new();
      node_count = waes_pkg::NCOUNT_RST;
      mismatches = 0;
      foreach (degree[i]) degree[i] = '0;
    endfunction

    function bit node_in_range(logic [waes_pkg::NODE_W-1:0] n);
      int lim;
      lim = (int'(node_count) < NODES) ? int'(node_count) : NODES;
      return int'(n) < lim;
    endfunction

    function int find_slot(logic [waes_pkg::NODE_W-1:0] a, logic [waes_pkg::NODE_W-1:0] b);
      for (int i = 0; i < int'(degree[a]); i++) begin
        if (target[a][i] == b) return i;
      end
      return -1;
    endfunction

    function logic [waes_pkg::STAT_W-1:0] insert_edge(logic [waes_pkg::NODE_W-1:0] a,
                                                       logic [waes_pkg::NODE_W-1:0] b,
                                                       logic signed [31:0] w);
      if (find_slot(a, b) >= 0) return waes_pkg::STAT_OK;
      if (int'(degree[a]) >= MAX_DEG) return waes_pkg::STAT_FULL;
      target[a][degree[a]] = b;
      weight[a][degree[a]] = w;
      degree[a] = degree[a] + 4'd1;
      return waes_pkg::STAT_OK;
    endfunction

    function void push(logic [waes_pkg::STAT_W-1:0] st, logic con, logic [31:0] w,
                       logic [waes_pkg::NODE_W-1:0] nb, logic iv, logic lst);
      waes_pkg::res_t r;
      r.status = st;
      r.connected = con;
      r.weight_out = w;
      r.neighbour = nb;
      r.item_valid = iv;
      r.last = lst;
      pending.insert(pending.size(), r);
    endfunction

    function void push_plain(logic [waes_pkg::STAT_W-1:0] st);
      push(st, 1'b0, 32'd0, '0, 1'b0, 1'b1);
    endfunction

    function void note_request(logic [waes_pkg::OP_W-1:0] op, logic [waes_pkg::NODE_W-1:0] a,
                               logic [waes_pkg::NODE_W-1:0] b, logic signed [31:0] w);
      logic [waes_pkg::STAT_W-1:0] s1, s2;
      int slot;
      if (op > waes_pkg::OP_LIST) return;
      if (op == waes_pkg::OP_LIST) begin
        if (!node_in_range(a)) push_plain(waes_pkg::STAT_INVALID);
        else if (degree[a] == 4'd0) push_plain(waes_pkg::STAT_OK);
        else begin
          for (int k = 0; k < int'(degree[a]); k++)
            push(waes_pkg::STAT_OK, 1'b0, 32'd0, target[a][k], 1'b1,
                 k + 1 == int'(degree[a]));
        end
        return;
      end
      if (!node_in_range(a) || !node_in_range(b)) begin
        push_plain(waes_pkg::STAT_INVALID);
        return;
      end
      case (op)
        waes_pkg::OP_ADD: begin
          push_plain(insert_edge(a, b, w));
        end
        waes_pkg::OP_ADD_UNDIR: begin
          s1 = insert_edge(a, b, w);
          s2 = insert_edge(b, a, w);
          push_plain((s1 != waes_pkg::STAT_OK || s2 != waes_pkg::STAT_OK) ?
                     waes_pkg::STAT_FULL : waes_pkg::STAT_OK);
        end
        waes_pkg::OP_IS_CONN: begin
          push(waes_pkg::STAT_OK, find_slot(a, b) >= 0, 32'd0, '0, 1'b0, 1'b1);
        end
        default: begin
          slot = find_slot(a, b);
          if (slot < 0) push_plain(waes_pkg::STAT_NO_EDGE);
          else push(waes_pkg::STAT_OK, 1'b1, weight[a][slot], '0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_answer(waes_pkg::res_t got);
      waes_pkg::res_t want;
      if (pending.size() == 0) begin
        $error("result item with nothing expected");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.connected !== want.connected) begin
        $error("connected: expected %0d, got %0d", want.connected, got.connected);
        mismatches++;
      end
      if (got.weight_out !== want.weight_out) begin
        $error("weight_out: expected %0d, got %0d",
               $signed(want.weight_out), $signed(got.weight_out));
        mismatches++;
      end
      if (got.neighbour !== want.neighbour) begin
        $error("neighbour: expected %0d, got %0d", want.neighbour, got.neighbour);
        mismatches++;
      end
      if (got.item_valid !== want.item_valid) begin
        $error("item_valid: expected %0d, got %0d", want.item_valid, got.item_valid);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [waes_pkg::NCOUNT_W-1:0] cfg_node_count = waes_pkg::NCOUNT_RST;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [waes_pkg::OP_W-1:0] in_operation = waes_pkg::OP_ADD;
  logic [waes_pkg::NODE_W-1:0] in_node_from = '0;
  logic [waes_pkg::NODE_W-1:0] in_node_to = '0;
  logic signed [31:0] in_edge_weight = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [waes_pkg::STAT_W-1:0] out_status;
  logic out_connected;
  logic signed [31:0] out_weight_out;
  logic [waes_pkg::NODE_W-1:0] out_neighbour;
  logic out_item_valid;
  logic out_last;

  waes_pkg::res_t seen_answer;
  adjacency_tracker tracker;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned cycle_count = 0;

  assign seen_answer = {out_status, out_connected, out_weight_out, out_neighbour,
                        out_item_valid, out_last};

  weighted_adjacency_edge_store_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_node_count (cfg_node_count),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_node_from   (in_node_from),
    .in_node_to     (in_node_to),
    .in_edge_weight (in_edge_weight),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_connected  (out_connected),
    .out_weight_out (out_weight_out),
    .out_neighbour  (out_neighbour),
    .out_item_valid (out_item_valid),
    .out_last       (out_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_answer(seen_answer);
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  task automatic send_item(input logic [waes_pkg::OP_W-1:0] op,
                           input logic [waes_pkg::NODE_W-1:0] a,
                           input logic [waes_pkg::NODE_W-1:0] b,
                           input logic signed [31:0] w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_node_from <= a;
    in_node_to <= b;
    in_edge_weight <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_request(op, a, b, w);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [waes_pkg::NCOUNT_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_node_count <= value;
    @(posedge clk);
    tracker.node_count = value;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [waes_pkg::NODE_W-1:0] pick_node();
    logic [31:0] r;
    if ($urandom_range(99) < 75) r = $urandom_range(11);
    else r = $urandom_range(NODES - 1);
    return r[waes_pkg::NODE_W-1:0];
  endfunction

  function automatic logic signed [31:0] pick_weight();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(input int count);
    int done;
    int pick;
    logic [waes_pkg::OP_W-1:0] op;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        case ($urandom_range(2))
          0: op = OP_RSVD_5;
          1: op = OP_RSVD_6;
          default: op = OP_RSVD_7;
        endcase
      end
      else if (pick < 35) op = waes_pkg::OP_ADD;
      else if (pick < 50) op = waes_pkg::OP_ADD_UNDIR;
      else if (pick < 65) op = waes_pkg::OP_IS_CONN;
      else if (pick < 85) op = waes_pkg::OP_GET_WT;
      else op = waes_pkg::OP_LIST;
      send_item(op, pick_node(), pick_node(), pick_weight());
      if (op <= waes_pkg::OP_LIST) done++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 26;
    receiver_idle_pct = 88;

    send_item(waes_pkg::OP_LIST, 6'd0, 6'd0, 32'sd0);
    send_item(waes_pkg::OP_ADD, 6'd0, 6'd63, 32'sh7fffffff);
    send_item(waes_pkg::OP_ADD, 6'd0, 6'd63, 32'sh12345678);
    send_item(waes_pkg::OP_GET_WT, 6'd0, 6'd63, 32'sd0);
    send_item(waes_pkg::OP_ADD, 6'd63, 6'd0, 32'sh80000000);
    send_item(waes_pkg::OP_GET_WT, 6'd63, 6'd0, 32'sd0);
    send_item(waes_pkg::OP_IS_CONN, 6'd0, 6'd63, 32'sd0);
    send_item(waes_pkg::OP_IS_CONN, 6'd63, 6'd5, 32'sd0);
    send_item(waes_pkg::OP_GET_WT, 6'd5, 6'd6, 32'sd0);
    send_item(waes_pkg::OP_ADD_UNDIR, 6'd5, 6'd7, -32'sd1);
    send_item(waes_pkg::OP_ADD_UNDIR, 6'd9, 6'd9, 32'sd3);
    for (int i = 0; i < MAX_DEG; i++) send_item(waes_pkg::OP_ADD, 6'd1, 6'(10 + i), i);
    send_item(waes_pkg::OP_ADD, 6'd1, 6'd18, 32'sd99);
    send_item(waes_pkg::OP_ADD_UNDIR, 6'd1, 6'd18, -32'sd7);
    send_item(waes_pkg::OP_LIST, 6'd1, 6'd0, 32'sd0);
    send_item(waes_pkg::OP_LIST, 6'd18, 6'd0, 32'sd0);
    send_item(OP_RSVD_5, 6'd2, 6'd3, 32'sd4);
    send_item(OP_RSVD_7, 6'd63, 6'd63, -32'sd1);
    quiesce();

    write_node_count(7'd20);
    send_item(waes_pkg::OP_ADD, 6'd0, 6'd20, 32'sd1);
    send_item(waes_pkg::OP_LIST, 6'd63, 6'd0, 32'sd0);
    send_item(waes_pkg::OP_GET_WT, 6'd30, 6'd0, 32'sd0);
    quiesce();

    write_node_count(7'd64);
    random_items(20);
    quiesce();
    random_items(18);
    quiesce();

    write_node_count(7'd0);
    random_items(8);
    quiesce();

    sender_idle_pct = 88;
    receiver_idle_pct = 26;
    write_node_count(7'd127);
    random_items(40);
    quiesce();

    write_node_count(7'd1);
    random_items(8);
    quiesce();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_node_count(7'd37);
    random_items(30);
    quiesce();

    if (tracker.mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
